// File: hw/rtl/rldc_pkg.sv
// shared types and constants for the run-length decoder with glyph-cell remapping
`timescale 1ns / 1ps

package rldc_pkg;

    localparam int CELL_WIDTH   = 8;
    localparam int CELL_BITS    = 3;
    localparam int MAX_SEGMENTS = 17;
    localparam int OUT_ADDR_W   = 12;
    localparam int HEIGHT_W     = 4;
    localparam int OFFSET_W     = 3;
    localparam int LEN_W        = 4;
    localparam int SEG_CNT_W    = 5;
    localparam int RUN_CNT_W    = 7;

    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = 4'd1;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 4'd8;

    // configuration register indexes
    localparam logic CFG_GLYPH_HEIGHT = 1'b0;
    localparam logic CFG_START_OFFSET = 1'b1;

    // input op codes
    localparam logic OP_BEGIN = 1'b0;
    localparam logic OP_BYTE  = 1'b1;

    typedef struct packed {
        logic [OUT_ADDR_W-1:0] write_address;
        logic [7:0]            pixel_value;
        logic [LEN_W-1:0]      run_length;
        logic                  last;
        logic                  finished;
    } rldc_result_t;

endpackage

// File: hw/rtl/rle_decode_column_rearrange_top.sv
// top level: configuration registers, output register and the decode sequencer
`timescale 1ns / 1ps

// Run-length decoder that writes a ROW_PIXELS wide strip as 8-pixel-wide glyph cells.
// Input items on s_*: tuser is the op (0 starts a new decode at start_offset,
// 1 carries a stream byte in tdata). Result items on m_*: a write segment of
// up to 8 contiguous addresses with one value, tlast on the final result of
// an input item, tuser set when the decode has ended (end code or full strip).
// Control bytes, literal bytes and begin items are handled without leaving the idle
// state; a literal result is in the output register in the cycle after acceptance.
// A repeat value byte walks the run through the shared address mapper one
// pixel per cycle, holding at a segment boundary while the receiver stalls.
// s_tready stays low meanwhile.
// The output register frees up in the cycle it is taken, so a new item is
// accepted while m_tready is high even with a result pending.
// Reset (aresetn low, synchronous) clears the decode state and sets glyph_height to 8
// and start_offset to 1. The user writes registers through cfg_wr_en/cfg_index/cfg_wdata
// only while no item is in progress; the block itself does not enforce this.

module rle_decode_column_rearrange_top
    import rldc_pkg::*;
#(
    parameter int ROW_PIXELS = 320
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // stream_byte
    input  logic [0:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // write_address[11:0], pixel_value[19:12], run_length[23:20]
    output logic        m_tlast,
    output logic [0:0]  m_tuser    // finished
);

    logic [HEIGHT_W-1:0] glyph_height_reg, glyph_height_next;
    logic [OFFSET_W-1:0] start_offset_reg, start_offset_next;
    logic                m_valid_reg, m_valid_next;
    rldc_result_t        m_res_reg, m_res_next;

    logic [HEIGHT_W-1:0] height_eff;
    logic                out_free;
    logic                res_valid;
    rldc_result_t        res;

    always_comb begin
        glyph_height_next = glyph_height_reg;
        start_offset_next = start_offset_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_GLYPH_HEIGHT: glyph_height_next = cfg_wdata;
                CFG_START_OFFSET: start_offset_next = cfg_wdata[OFFSET_W-1:0];
                default:          glyph_height_next = glyph_height_reg;
            endcase
        end
    end

    always_comb begin
        priority if (glyph_height_reg < HEIGHT_MIN) begin
            height_eff = HEIGHT_MIN;
        end else if (glyph_height_reg > HEIGHT_MAX) begin
            height_eff = HEIGHT_MAX;
        end else begin
            height_eff = glyph_height_reg;
        end
    end

    assign out_free = !m_valid_reg || m_tready;

    rldc_seq #(
        .ROW_PIXELS (ROW_PIXELS)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_tvalid),
        .s_op         (s_tuser[0]),
        .s_byte       (s_tdata),
        .s_ready      (s_tready),
        .out_free     (out_free),
        .height       (height_eff),
        .start_offset (start_offset_reg),
        .res_valid    (res_valid),
        .res          (res)
    );

    always_comb begin
        m_res_next   = m_res_reg;
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_res_next   = res;
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glyph_height_reg <= HEIGHT_MAX;
            start_offset_reg <= OFFSET_W'(1);
            m_valid_reg      <= 1'b0;
        end else begin
            glyph_height_reg <= glyph_height_next;
            start_offset_reg <= start_offset_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_res_reg.run_length, m_res_reg.pixel_value, m_res_reg.write_address};
    assign m_tlast  = m_res_reg.last;
    assign m_tuser  = m_res_reg.finished;

endmodule

// File: hw/rtl/rldc_addr_unit.sv
// shared address mapper: strip position to glyph-cell address and contiguity compare
`timescale 1ns / 1ps

module rldc_addr_unit
    import rldc_pkg::*;
#(
    parameter int ROW_PIXELS = 320
) (
    input  logic [$clog2(ROW_PIXELS)-1:0]       col,
    input  logic [HEIGHT_W-1:0]                 row,
    input  logic [HEIGHT_W-1:0]                 height,
    input  logic [$clog2(ROW_PIXELS*8+128)-1:0] seg_addr,
    input  logic [LEN_W-1:0]                    seg_len,
    output logic [$clog2(ROW_PIXELS*8+128)-1:0] addr,
    output logic                                match
);

    localparam int COL_W  = $clog2(ROW_PIXELS);
    localparam int ADDR_W = $clog2(ROW_PIXELS*8+128);
    // how far each row start sits past a cell boundary in the flat position
    localparam logic [CELL_BITS-1:0] ROW_SKEW = CELL_BITS'(ROW_PIXELS % CELL_WIDTH);

    logic [COL_W-1:0]          cell_idx;
    logic [COL_W+HEIGHT_W-1:0] cell_prod;
    logic [CELL_BITS-1:0]      pix_lo;

    always_comb begin
        cell_idx  = col >> CELL_BITS;
        cell_prod = (COL_W+HEIGHT_W)'(cell_idx) * (COL_W+HEIGHT_W)'(height);
        // low bits of the flat position, not of the column
        pix_lo    = col[CELL_BITS-1:0] + CELL_BITS'(row[CELL_BITS-1:0] * ROW_SKEW);
        addr      = ADDR_W'(pix_lo)
                  + (ADDR_W'(row) << CELL_BITS)
                  + (ADDR_W'(cell_prod) << CELL_BITS);
        match     = (addr == seg_addr + ADDR_W'(seg_len));
    end

endmodule

// File: hw/rtl/rldc_seq.sv
// decode sequencer: control byte phases, repeat-run segmenting and position tracking
`timescale 1ns / 1ps

module rldc_seq
    import rldc_pkg::*;
#(
    parameter int ROW_PIXELS = 320
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_op,
    input  logic [7:0]            s_byte,
    output logic                  s_ready,
    input  logic                  out_free,
    input  logic [HEIGHT_W-1:0]   height,
    input  logic [OFFSET_W-1:0]   start_offset,
    output logic                  res_valid,
    output rldc_result_t          res
);

    localparam int COL_W  = $clog2(ROW_PIXELS);
    localparam int ADDR_W = $clog2(ROW_PIXELS*8+128);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(ROW_PIXELS - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    typedef enum logic [1:0] {
        PH_CONTROL = 2'd0,
        PH_REPEAT  = 2'd1,
        PH_LITERAL = 2'd2
    } phase_t;

    state_t                 state_reg, state_next;
    phase_t                 phase_reg, phase_next;
    logic [RUN_CNT_W-1:0]   remaining_reg, remaining_next;
    logic                   done_reg, done_next;
    logic [HEIGHT_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [RUN_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [7:0]             val_reg, val_next;
    logic [ADDR_W-1:0]      seg_addr_reg, seg_addr_next;
    logic [LEN_W-1:0]       seg_len_reg, seg_len_next;
    logic [SEG_CNT_W-1:0]   nseg_reg, nseg_next;

    logic [ADDR_W-1:0]      addr_cur;
    logic                   addr_match;
    logic                   col_last;
    logic [COL_W-1:0]       adv_col;
    logic [HEIGHT_W-1:0]    adv_row;
    logic                   in_strip;
    logic                   can_step;
    logic                   more;
    logic                   accept;
    logic [RUN_CNT_W-1:0]   rem_dec;

    rldc_addr_unit #(
        .ROW_PIXELS (ROW_PIXELS)
    ) u_addr (
        .col      (col_reg),
        .row      (row_reg),
        .height   (height),
        .seg_addr (seg_addr_reg),
        .seg_len  (seg_len_reg),
        .addr     (addr_cur),
        .match    (addr_match)
    );

    always_comb begin
        col_last = (col_reg == LAST_COL);
        adv_col  = col_last ? '0 : col_reg + 1'b1;
        adv_row  = col_last ? row_reg + 1'b1 : row_reg;
        in_strip = (row_reg < height);
        can_step = (cnt_reg != '0) && in_strip;
        more     = can_step && (nseg_reg < SEG_CNT_W'(MAX_SEGMENTS - 1));
        s_ready  = (state_reg == ST_IDLE) && out_free;
        accept   = s_valid && s_ready;
        rem_dec  = (remaining_reg != '0) ? remaining_reg - 1'b1 : remaining_reg;
    end

    always_comb begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        done_next      = done_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        val_next       = val_reg;
        seg_addr_next  = seg_addr_reg;
        seg_len_next   = seg_len_reg;
        nseg_next      = nseg_reg;
        res_valid      = 1'b0;
        res            = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_BEGIN) begin
                        col_next       = COL_W'(start_offset);
                        row_next       = '0;
                        phase_next     = PH_CONTROL;
                        remaining_next = '0;
                        done_next      = 1'b0;
                    end else if (done_reg) begin
                        // bytes after the end are dropped
                    end else if (!in_strip) begin
                        // height shrunk under the current position
                        done_next    = 1'b1;
                        res_valid    = 1'b1;
                        res.last     = 1'b1;
                        res.finished = 1'b1;
                    end else begin
                        unique case (phase_reg)
                            PH_REPEAT: begin
                                phase_next     = PH_CONTROL;
                                remaining_next = '0;
                                cnt_next       = remaining_reg;
                                val_next       = s_byte;
                                seg_len_next   = '0;
                                nseg_next      = '0;
                                state_next     = ST_RUN;
                            end
                            PH_LITERAL: begin
                                res_valid         = 1'b1;
                                res.write_address = OUT_ADDR_W'(addr_cur);
                                res.pixel_value   = s_byte;
                                res.run_length    = LEN_W'(1);
                                res.last          = 1'b1;
                                res.finished      = (adv_row >= height);
                                col_next          = adv_col;
                                row_next          = adv_row;
                                remaining_next    = rem_dec;
                                if (rem_dec == '0) begin
                                    phase_next = PH_CONTROL;
                                end
                                if (adv_row >= height) begin
                                    done_next = 1'b1;
                                end
                            end
                            default: begin
                                if (s_byte == 8'd0) begin
                                    done_next      = 1'b1;
                                    phase_next     = PH_CONTROL;
                                    remaining_next = '0;
                                    res_valid      = 1'b1;
                                    res.last       = 1'b1;
                                    res.finished   = 1'b1;
                                end else if (s_byte[7]) begin
                                    phase_next     = PH_REPEAT;
                                    remaining_next = s_byte[6:0];
                                end else begin
                                    phase_next     = PH_LITERAL;
                                    remaining_next = s_byte[6:0];
                                end
                            end
                        endcase
                    end
                end
            end
            ST_RUN: begin
                if (seg_len_reg == '0) begin
                    // first pixel of the run, or a repeat of zero
                    if (can_step) begin
                        seg_addr_next = addr_cur;
                        seg_len_next  = LEN_W'(1);
                        col_next      = adv_col;
                        row_next      = adv_row;
                        cnt_next      = cnt_reg - 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end else if (can_step && (seg_len_reg < LEN_W'(CELL_WIDTH)) && addr_match) begin
                    seg_len_next = seg_len_reg + 1'b1;
                    col_next     = adv_col;
                    row_next     = adv_row;
                    cnt_next     = cnt_reg - 1'b1;
                end else if (out_free) begin
                    // close the segment, and if the run goes on, open the next one in the same cycle
                    res_valid         = 1'b1;
                    res.write_address = OUT_ADDR_W'(seg_addr_reg);
                    res.pixel_value   = val_reg;
                    res.run_length    = seg_len_reg;
                    res.last          = !more;
                    res.finished      = !more && !in_strip;
                    if (more) begin
                        seg_addr_next = addr_cur;
                        seg_len_next  = LEN_W'(1);
                        col_next      = adv_col;
                        row_next      = adv_row;
                        cnt_next      = cnt_reg - 1'b1;
                        nseg_next     = nseg_reg + 1'b1;
                    end else begin
                        state_next = ST_IDLE;
                        if (!in_strip) begin
                            done_next = 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_CONTROL;
            remaining_reg <= '0;
            done_reg      <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            done_reg      <= done_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg      <= cnt_next;
        val_reg      <= val_next;
        seg_addr_reg <= seg_addr_next;
        seg_len_reg  <= seg_len_next;
        nseg_reg     <= nseg_next;
    end

endmodule

// File: bench/rle_decode_column_rearrange_top_tb.sv
// self-checking bench for the run-length decoder with glyph-cell address remapping
`timescale 1ns / 1ps

module rle_decode_column_rearrange_top_tb;
    import rldc_pkg::*;

    localparam int ROW_PIXELS    = 320;
    localparam int STALL_LIMIT   = 1500;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 20;
    localparam int ITEM_TARGET   = 310;

    typedef enum logic [1:0] {
        EXPECT_CONTROL,
        EXPECT_REPEAT_VALUE,
        EXPECT_LITERAL
    } decode_phase_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_index;
    logic [3:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // stream_byte
    logic [0:0]  s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // write_address[11:0], pixel_value[19:12], run_length[23:20]
    logic        m_tlast;
    logic [0:0]  m_tuser;   // finished

    // decoder state as predicted by the bench
    logic [3:0]    glyph_height_q = 4'd8;
    logic [2:0]    start_offset_q = 3'd1;
    decode_phase_t phase_q        = EXPECT_CONTROL;
    logic [6:0]    run_left_q     = '0;
    int unsigned   pos_q          = 0;
    bit            done_q         = 1'b0;
    bit            item_ignored;

    rldc_result_t pending_segments[$];
    rldc_result_t oldest_seg;
    int           mismatches    = 0;
    int           idle_cycles   = 0;
    int           counted_items = 0;
    bit           idle_on       = 1'b1;
    bit           hold_request  = 1'b0;

    rle_decode_column_rearrange_top #(
        .ROW_PIXELS(ROW_PIXELS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned cell_address(input int unsigned p, input int unsigned h);
        return (p % CELL_WIDTH) + (p / ROW_PIXELS) * CELL_WIDTH
            + ((p % ROW_PIXELS) / CELL_WIDTH) * CELL_WIDTH * h;
    endfunction

    function automatic rldc_result_t make_seg(input int unsigned addr, input int unsigned val,
                                              input int unsigned len, input bit fin);
        rldc_result_t seg;
        seg.write_address = addr[OUT_ADDR_W-1:0];
        seg.pixel_value   = val[7:0];
        seg.run_length    = len[LEN_W-1:0];
        seg.last          = 1'b0;
        seg.finished      = fin;
        return seg;
    endfunction

    // works out the segments one accepted item causes and queues them
    task automatic decode_item(input logic op, input logic [7:0] b);
        int unsigned  h;
        int unsigned  lim;
        int unsigned  cnt;
        int unsigned  a0;
        int unsigned  len;
        rldc_result_t segs[$];
        h = (glyph_height_q < HEIGHT_MIN) ? HEIGHT_MIN :
            (glyph_height_q > HEIGHT_MAX) ? HEIGHT_MAX : glyph_height_q;
        lim = ROW_PIXELS * h;
        item_ignored = 1'b0;
        if (op == OP_BEGIN) begin
            pos_q      = start_offset_q;
            phase_q    = EXPECT_CONTROL;
            run_left_q = '0;
            done_q     = 1'b0;
            return;
        end
        if (done_q) begin
            item_ignored = 1'b1;
            return;
        end
        if (pos_q >= lim) begin
            // strip already full after the height shrank
            done_q = 1'b1;
            segs.push_back(make_seg(0, 0, 0, 1'b1));
        end else begin
            case (phase_q)
                EXPECT_REPEAT_VALUE: begin
                    cnt        = run_left_q;
                    phase_q    = EXPECT_CONTROL;
                    run_left_q = '0;
                    while (cnt > 0 && pos_q < lim && segs.size() < MAX_SEGMENTS) begin
                        a0  = cell_address(pos_q, h);
                        len = 1;
                        pos_q++;
                        cnt--;
                        while (cnt > 0 && pos_q < lim && len < CELL_WIDTH
                               && cell_address(pos_q, h) == a0 + len) begin
                            len++;
                            pos_q++;
                            cnt--;
                        end
                        segs.push_back(make_seg(a0, b, len, 1'b0));
                    end
                    if (pos_q >= lim) begin
                        done_q = 1'b1;
                        if (segs.size() > 0) segs[segs.size()-1].finished = 1'b1;
                    end
                end
                EXPECT_LITERAL: begin
                    segs.push_back(make_seg(cell_address(pos_q, h), b, 1, 1'b0));
                    pos_q++;
                    if (run_left_q > 0) run_left_q--;
                    if (run_left_q == 0) phase_q = EXPECT_CONTROL;
                    if (pos_q >= lim) begin
                        done_q = 1'b1;
                        segs[0].finished = 1'b1;
                    end
                end
                default: begin
                    if (b == 8'd0) begin
                        done_q     = 1'b1;
                        phase_q    = EXPECT_CONTROL;
                        run_left_q = '0;
                        segs.push_back(make_seg(0, 0, 0, 1'b1));
                    end else if (b[7]) begin
                        phase_q    = EXPECT_REPEAT_VALUE;
                        run_left_q = b[6:0];
                    end else begin
                        phase_q    = EXPECT_LITERAL;
                        run_left_q = b[6:0];
                    end
                end
            endcase
        end
        if (segs.size() > 0) segs[segs.size()-1].last = 1'b1;
        foreach (segs[i]) pending_segments.push_back(segs[i]);
    endtask

    task automatic offer_item(input logic op, input logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        decode_item(op, b);
        if (!item_ignored) counted_items++;
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_GLYPH_HEIGHT) glyph_height_q = val;
        else start_offset_q = val[2:0];
    endtask

    // stop offering, wait for every queued segment, then let the block go quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_segments.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // receiver: random stall before each item, with a long hold on request
    initial begin : receiver
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_request) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end
            stall = idle_on ? $urandom_range(0, 5) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_segments.size() == 0) begin
                $error("unexpected item: tdata %h tlast %b tuser %b", m_tdata, m_tlast, m_tuser);
                mismatches++;
            end else begin
                oldest_seg = pending_segments.pop_front();
                if (m_tdata[11:0] !== oldest_seg.write_address) begin
                    $error("write_address: expected %0d, got %0d",
                           oldest_seg.write_address, m_tdata[11:0]);
                    mismatches++;
                end
                if (m_tdata[19:12] !== oldest_seg.pixel_value) begin
                    $error("pixel_value: expected %0d, got %0d",
                           oldest_seg.pixel_value, m_tdata[19:12]);
                    mismatches++;
                end
                if (m_tdata[23:20] !== oldest_seg.run_length) begin
                    $error("run_length: expected %0d, got %0d",
                           oldest_seg.run_length, m_tdata[23:20]);
                    mismatches++;
                end
                if (m_tlast !== oldest_seg.last) begin
                    $error("last: expected %0b, got %0b", oldest_seg.last, m_tlast);
                    mismatches++;
                end
                if (m_tuser[0] !== oldest_seg.finished) begin
                    $error("finished: expected %0b, got %0b", oldest_seg.finished, m_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // reset values, no begin item: literals, a full-length repeat, a zero repeat, end code
    task automatic test_stream_basics();
        offer_item(OP_BYTE, 8'h02);
        offer_item(OP_BYTE, 8'h00);
        offer_item(OP_BYTE, 8'hFF);
        offer_item(OP_BYTE, 8'hFF);
        offer_item(OP_BYTE, 8'hA5);
        offer_item(OP_BYTE, 8'h80);
        offer_item(OP_BYTE, 8'h3C);
        offer_item(OP_BYTE, 8'h00);
        offer_item(OP_BYTE, 8'h55);
        settle();
    endtask

    // single-row strip filled by repeat runs; the tail of the last run is dropped
    task automatic test_strip_full();
        write_reg(CFG_GLYPH_HEIGHT, 4'd1);
        write_reg(CFG_START_OFFSET, 4'd7);
        offer_item(OP_BEGIN, 8'hFF);
        offer_item(OP_BYTE, 8'hFF);
        offer_item(OP_BYTE, 8'h11);
        offer_item(OP_BYTE, 8'hFF);
        offer_item(OP_BYTE, 8'h22);
        offer_item(OP_BYTE, 8'hFF);
        offer_item(OP_BYTE, 8'h33);
        offer_item(OP_BYTE, 8'h44);
        settle();
    endtask

    // decode past a one-row strip, then shrink the height before the next byte
    task automatic test_height_shrink();
        write_reg(CFG_GLYPH_HEIGHT, 4'd8);
        write_reg(CFG_START_OFFSET, 4'd0);
        offer_item(OP_BEGIN, 8'h00);
        repeat (3) begin
            offer_item(OP_BYTE, 8'hFF);
            offer_item(OP_BYTE, 8'h01);
        end
        settle();
        write_reg(CFG_GLYPH_HEIGHT, 4'd1);
        offer_item(OP_BYTE, 8'h09);
        settle();
    endtask

    // receiver holds off while items keep coming, then a burst with no idling
    task automatic test_backpressure();
        write_reg(CFG_GLYPH_HEIGHT, 4'd7);
        write_reg(CFG_START_OFFSET, 4'd1);
        hold_request = 1'b1;
        offer_item(OP_BEGIN, 8'h00);
        offer_item(OP_BYTE, 8'h08);
        repeat (8) offer_item(OP_BYTE, 8'($urandom_range(0, 255)));
        offer_item(OP_BYTE, 8'h90);
        offer_item(OP_BYTE, 8'($urandom_range(0, 255)));
        offer_item(OP_BYTE, 8'h85);
        offer_item(OP_BYTE, 8'($urandom_range(0, 255)));
        settle();
        idle_on = 1'b0;
        repeat (4) begin
            offer_item(OP_BYTE, 8'($urandom_range(129, 255)));
            offer_item(OP_BYTE, 8'($urandom_range(0, 255)));
            offer_item(OP_BYTE, 8'h01);
            offer_item(OP_BYTE, 8'($urandom_range(0, 255)));
        end
        settle();
        idle_on = 1'b1;
    endtask

    // one decode: begin, then mostly well-formed runs, some noise and cut-off literals
    task automatic random_stream();
        int kind;
        int count;
        int sent;
        offer_item(OP_BEGIN, 8'($urandom_range(0, 255)));
        while (!done_q && counted_items < ITEM_TARGET) begin
            kind = $urandom_range(0, 19);
            if (kind <= 6) begin
                count = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
                sent  = (count > 12) ? $urandom_range(1, 12) : count;
                offer_item(OP_BYTE, 8'(count));
                for (int i = 0; i < sent && !done_q; i++)
                    offer_item(OP_BYTE, 8'($urandom_range(0, 255)));
                if (sent < count) return;
            end else if (kind <= 13) begin
                count = $urandom_range(0, 1) ? $urandom_range(0, 10) : $urandom_range(0, 127);
                offer_item(OP_BYTE, 8'(8'h80 | count));
                offer_item(OP_BYTE, 8'($urandom_range(0, 255)));
            end else if (kind == 14) begin
                offer_item(OP_BYTE, 8'h00);
            end else begin
                offer_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_random_streams();
        logic [3:0] heights [10] = '{4'd8, 4'd7, 4'd1, 4'd0, 4'd15, 4'd3, 4'd2, 4'd8, 4'd12, 4'd1};
        logic [3:0] offsets [10] = '{4'd1, 4'd0, 4'd7, 4'd3, 4'd5, 4'd15, 4'd0, 4'd7, 4'd2, 4'd0};
        int setting;
        int phase_end;
        setting = 0;
        while (counted_items < ITEM_TARGET) begin
            settle();
            write_reg(CFG_GLYPH_HEIGHT, heights[setting % 10]);
            write_reg(CFG_START_OFFSET, offsets[setting % 10]);
            idle_on   = (setting % 3 != 2);
            phase_end = counted_items + 35;
            while (counted_items < phase_end && counted_items < ITEM_TARGET) random_stream();
            setting++;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = OP_BYTE;
        cfg_wr_en = 1'b0;
        cfg_index = CFG_GLYPH_HEIGHT;
        cfg_wdata = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_stream_basics();
        test_strip_full();
        test_height_shrink();
        test_backpressure();
        test_random_streams();
        settle();
        if (mismatches == 0 && pending_segments.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
